// ----- rtl/core/cpc_pkg.sv -----
package cpc_pkg;

  localparam int VALUE_W   = 16;
  localparam int PAIRS_W   = 11;
  localparam logic [PAIRS_W-1:0] PAIRS_MAX = {PAIRS_W{1'b1}};

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [PAIRS_W-1:0] coprime_pairs;
    logic               overflow;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_GCD,
    S_DONE
  } state_t;

endpackage

// ----- rtl/core/coprime_pair_counter.sv -----
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | in_t  {value, last}
// out     | output    | out_valid / out_ready  | out_t {coprime_pairs, overflow}
//
// The block accepts one request per cycle while it is idle.
// After a last request the pair scan runs: n(n-1)/2 pairs, each a memory read and
// operand load plus the binary gcd loop through one shared subtract/compare unit.
// in_ready stays low until the count is latched into the output register; a stalled
// output holds the scan at its end.
// Synchronous active-low reset clears the fill count, overflow flag and handshakes.
module coprime_pair_counter
  import cpc_pkg::*;
#(
  parameter int MAX_VALUES = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int IW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int CW = $clog2(MAX_VALUES + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_VALUES);

  state_t state_r, state_nxt;

  logic [CW-1:0]      fill_r, fill_nxt;
  logic               drop_r, drop_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic [PAIRS_W-1:0] cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] ga_r, ga_nxt;
  logic [VALUE_BITS-1:0] gb_r, gb_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic [VALUE_BITS-1:0] mem [MAX_VALUES];
  logic [VALUE_BITS-1:0] rd_a_r, rd_b_r;
  logic [VALUE_BITS-1:0] v_in;
  logic                  wr_en;

  // gcd step signals
  logic                  a_gt;
  logic [VALUE_BITS-1:0] diff;
  logic                  gcd_done, gcd_hit;

  generate
    if (VALUE_BITS <= VALUE_W) begin : g_narrow
      assign v_in = in_data.value[VALUE_BITS-1:0];
    end else begin : g_wide
      assign v_in = {{(VALUE_BITS-VALUE_W){1'b0}}, in_data.value};
    end
  endgenerate

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign wr_en = in_valid && in_ready && (fill_r != FULL);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[IW-1:0]] <= v_in;
    end
    rd_a_r <= mem[i_r[IW-1:0]];
    rd_b_r <= mem[j_r[IW-1:0]];
  end

  // Binary gcd, one step per cycle; only coprimality is needed.
  always_comb begin
    a_gt     = ga_r > gb_r;
    diff     = a_gt ? (ga_r - gb_r) : (gb_r - ga_r);
    gcd_done = 1'b0;
    gcd_hit  = 1'b0;
    ga_nxt   = ga_r;
    gb_nxt   = gb_r;
    if (ga_r == '0) begin
      gcd_done = 1'b1;
      gcd_hit  = (gb_r == VALUE_BITS'(1));
    end else if (gb_r == '0) begin
      gcd_done = 1'b1;
      gcd_hit  = (ga_r == VALUE_BITS'(1));
    end else if (!ga_r[0] && !gb_r[0]) begin
      gcd_done = 1'b1;  // common factor of two
    end else if (!ga_r[0]) begin
      ga_nxt = ga_r >> 1;
    end else if (!gb_r[0]) begin
      gb_nxt = gb_r >> 1;
    end else if (ga_r == gb_r) begin
      gcd_done = 1'b1;
      gcd_hit  = (ga_r == VALUE_BITS'(1));
    end else if (a_gt) begin
      ga_nxt = diff >> 1;
    end else begin
      gb_nxt = diff >> 1;
    end
    if (state_r == S_LOAD) begin
      ga_nxt = rd_a_r;
      gb_nxt = rd_b_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (fill_r != FULL) begin
            fill_nxt = fill_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_data.last) begin
            cnt_nxt = '0;
            i_nxt   = '0;
            j_nxt   = CW'(1);
            if (fill_nxt < CW'(2)) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_READ;
            end
          end
        end
      end
      S_READ: state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_GCD;
      S_GCD: begin
        if (gcd_done) begin
          if (gcd_hit && cnt_r != PAIRS_MAX) begin
            cnt_nxt = cnt_r + PAIRS_W'(1);
          end
          if (j_r + CW'(1) < fill_r) begin
            j_nxt     = j_r + CW'(1);
            state_nxt = S_READ;
          end else if (i_r + CW'(2) < fill_r) begin
            i_nxt     = i_r + CW'(1);
            j_nxt     = i_r + CW'(2);
            state_nxt = S_READ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.coprime_pairs = cnt_r;
          out_data_nxt.overflow      = drop_r;
          fill_nxt                   = '0;
          drop_nxt                   = 1'b0;
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    cnt_r      <= cnt_nxt;
    ga_r       <= ga_nxt;
    gb_r       <= gb_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
